[sv/kst_pkg.sv]
// shared constants, key tables and types for the scancode translator
package kst_pkg;

    // scan byte and character widths
    localparam int unsigned SCAN_W  = 8;
    localparam int unsigned KEY_W   = 7;
    localparam int unsigned CHAR_W  = 7;
    // keymap memory: plain half then shifted half
    localparam int unsigned MAP_DEPTH = 256;
    localparam int unsigned MAP_AW    = 8;

    // special scan codes
    localparam logic [SCAN_W-1:0] LSHIFT_MAKE  = 8'd99;
    localparam logic [SCAN_W-1:0] RSHIFT_MAKE  = 8'd110;
    localparam logic [SCAN_W-1:0] LSHIFT_BREAK = 8'd227;
    localparam logic [SCAN_W-1:0] RSHIFT_BREAK = 8'd238;

    // shift-held bits
    typedef struct packed {
        logic right;
        logic left;
    } t_shift;

    // unshifted characters, indexed by key number
    localparam logic [CHAR_W-1:0] PLAIN_MAP [128] = '{
        // 0 .. 29
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 30 .. 43: digit row, backspace
        7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd48,
        7'd45, 7'd61, 7'd0, 7'd8,
        // 44 .. 53: tab at the end
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd9,
        // 54 .. 65: top letter row
        7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
        7'd111, 7'd112, 7'd91, 7'd93,
        // 66 .. 76
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 77 .. 89: home row, return
        7'd97, 7'd115, 7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107,
        7'd108, 7'd59, 7'd39, 7'd92, 7'd13,
        // 90 .. 99
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 100 .. 109: bottom row
        7'd122, 7'd120, 7'd99, 7'd118, 7'd98, 7'd110, 7'd109, 7'd44,
        7'd46, 7'd47,
        // 110 .. 120
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 121 .. 127: space bar
        7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    // shifted characters, indexed by key number
    localparam logic [CHAR_W-1:0] SHIFT_MAP [128] = '{
        // 0 .. 29
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 30 .. 43
        7'd33, 7'd64, 7'd35, 7'd36, 7'd37, 7'd94, 7'd38, 7'd42, 7'd40, 7'd41,
        7'd95, 7'd43, 7'd0, 7'd8,
        // 44 .. 53
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd9,
        // 54 .. 65
        7'd81, 7'd87, 7'd69, 7'd82, 7'd84, 7'd89, 7'd85, 7'd73,
        7'd79, 7'd80, 7'd123, 7'd125,
        // 66 .. 76
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 77 .. 89
        7'd65, 7'd83, 7'd68, 7'd70, 7'd71, 7'd72, 7'd74, 7'd75,
        7'd76, 7'd58, 7'd34, 7'd124, 7'd13,
        // 90 .. 99
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 100 .. 109
        7'd90, 7'd88, 7'd67, 7'd86, 7'd66, 7'd78, 7'd77, 7'd60,
        7'd62, 7'd63,
        // 110 .. 120
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        // 121 .. 127
        7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    // keymap contents at one memory address: top bit picks the shifted half
    function automatic logic [CHAR_W-1:0] keymap_entry(input logic [MAP_AW-1:0] addr);
        logic [KEY_W-1:0] key;
        key = addr[KEY_W-1:0];
        return addr[MAP_AW-1] ? SHIFT_MAP[key] : PLAIN_MAP[key];
    endfunction

endpackage

[sv/keyboard_scancode_translator_top.sv]
// top level of the keyboard scancode to ascii translator
//
// Input channel: one scan byte per word on i_scan_code, handshake
// i_in_valid / o_in_ready. Output channel: one ascii character per word on
// o_ascii_char, handshake o_out_valid / i_out_ready.
// Make bytes (bit 7 clear) and the two shift release bytes give no word;
// every other release byte gives exactly one character, 0 if unmapped.
// The shift press/release bytes update two shift-held flags; the character
// comes from the shifted half of the keymap if either flag is set after
// the current byte.
// Path: a taken byte's character is read into the keymap memory's read
// register, then moves on into the output register.
// Throughput: one byte per cycle after the keymap load while the receiver
// keeps i_out_ready high; set by the single read port of the keymap memory.
// Reset: shift flags clear, then the keymap memory is loaded from its
// constant tables; o_in_ready stays low during the load.
// Receiver stall: one finished character waits in the output register and
// one more in the memory read stage; input is held off only when both
// are occupied and the receiver is not taking a word.
module keyboard_scancode_translator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [kst_pkg::SCAN_W-1:0]  i_scan_code,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [kst_pkg::CHAR_W-1:0]  o_ascii_char
);

    kst_pkg::t_shift             r_shift;
    kst_pkg::t_shift             n_shift;
    logic                        r_s1_valid;
    logic                        r_out_valid;
    logic [kst_pkg::CHAR_W-1:0]  r_out_char;
    logic                        w_map_ready;
    logic                        w_in_acc;
    logic                        w_s1_move;
    logic                        w_has_result;
    logic [kst_pkg::MAP_AW-1:0]  w_raddr;
    logic [kst_pkg::CHAR_W-1:0]  w_rdata;

    // handshake control
    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = w_map_ready && (!r_s1_valid || w_s1_move);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // shift flag update for the current byte
    always_comb begin
        n_shift = r_shift;
        priority if (i_scan_code == kst_pkg::LSHIFT_MAKE) begin
            n_shift.left = 1'b1;
        end else if (i_scan_code == kst_pkg::RSHIFT_MAKE) begin
            n_shift.right = 1'b1;
        end else if (i_scan_code == kst_pkg::LSHIFT_BREAK) begin
            n_shift.left = 1'b0;
        end else if (i_scan_code == kst_pkg::RSHIFT_BREAK) begin
            n_shift.right = 1'b0;
        end else begin
            n_shift = r_shift;
        end
    end

    // release bytes other than the shift keys give a character
    assign w_has_result = i_scan_code[kst_pkg::SCAN_W-1]
                       && (i_scan_code != kst_pkg::LSHIFT_BREAK)
                       && (i_scan_code != kst_pkg::RSHIFT_BREAK);
    assign w_raddr      = {(n_shift.left || n_shift.right),
                           i_scan_code[kst_pkg::KEY_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (w_in_acc) begin
            r_shift <= n_shift;
        end
    end

    // keymap lookup
    kst_keymap u_keymap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_in_acc && w_has_result),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata),
        .o_ready (w_map_ready)
    );

    // read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= w_has_result;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_char <= w_rdata;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ascii_char = r_out_char;

    // no byte taken while the keymap is still loading
    a_no_accept_during_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_map_ready |-> !o_in_ready)
        else $error("byte accepted during keymap load");

    // left shift release clears the left flag
    a_lshift_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_scan_code == kst_pkg::LSHIFT_BREAK) |=> !r_shift.left)
        else $error("left shift flag not cleared");

    // make bytes never fill the read stage
    a_make_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_scan_code[kst_pkg::SCAN_W-1]) |=> !r_s1_valid)
        else $error("make byte produced a character");

    // a blocked read stage keeps its character
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |=> (r_s1_valid && $stable(w_rdata)))
        else $error("pending character lost under stall");

endmodule

[sv/kst_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module kst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/kst_keymap.sv]
// keymap memory with its load sequencer
module kst_keymap (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_re,
    input  logic [kst_pkg::MAP_AW-1:0]   i_raddr,
    output logic [kst_pkg::CHAR_W-1:0]   o_rdata,
    output logic                         o_ready
);

    logic [kst_pkg::MAP_AW-1:0] r_fill_addr;
    logic                       r_loaded;
    logic                       w_we;
    logic [kst_pkg::CHAR_W-1:0] w_wdata;

    // load sweep: one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_addr <= '0;
            r_loaded    <= 1'b0;
        end else if (!r_loaded) begin
            r_fill_addr <= r_fill_addr + 1'b1;
            if (r_fill_addr == {kst_pkg::MAP_AW{1'b1}}) begin
                r_loaded <= 1'b1;
            end
        end
    end

    assign w_we    = !r_loaded;
    assign w_wdata = kst_pkg::keymap_entry(r_fill_addr);
    assign o_ready = r_loaded;

    // table storage
    kst_ram #(
        .WIDTH (kst_pkg::CHAR_W),
        .DEPTH (kst_pkg::MAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill_addr),
        .i_wdata (w_wdata),
        .i_re    (i_re && r_loaded),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

endmodule

[verif/tb.sv]
// self-checking testbench for the keyboard scancode translator top level
`timescale 1ns / 1ps

module tb;

    localparam logic [kst_pkg::SCAN_W-1:0] BREAK_BIT = 8'h80;
    localparam int                RANDOM_WORDS = 1500;
    localparam int                SETTLE_CYCLES = 10;

    // one directed row: scan byte, and a hand-typed character where one is given
    typedef struct packed {
        logic [kst_pkg::SCAN_W-1:0] code;
        logic                       typed;
        logic [kst_pkg::CHAR_W-1:0] ch;
    } t_row;

    localparam int NUM_ROWS = 26;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{BREAK_BIT | 8'd77, 1'b1, 7'd97},   // 'a' release right after reset
        '{BREAK_BIT, 1'b1, 7'd0},            // lowest release byte, unmapped
        '{8'hff, 1'b1, 7'd0},                // highest release byte, unmapped
        '{8'h00, 1'b0, 7'd0},                // lowest make byte
        '{8'h7f, 1'b0, 7'd0},                // highest make byte
        '{kst_pkg::LSHIFT_MAKE, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd77, 1'b0, 7'd0},    // upper case under left shift
        '{8'hff, 1'b1, 7'd0},                // unmapped in the shifted half too
        '{kst_pkg::LSHIFT_BREAK, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd77, 1'b1, 7'd97},
        '{kst_pkg::RSHIFT_MAKE, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd30, 1'b0, 7'd0},    // digit row under right shift
        '{kst_pkg::RSHIFT_BREAK, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd30, 1'b1, 7'd49},
        '{kst_pkg::LSHIFT_BREAK, 1'b0, 7'd0}, // shift releases with no press
        '{kst_pkg::RSHIFT_BREAK, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd121, 1'b1, 7'd32},  // space bar
        '{kst_pkg::LSHIFT_MAKE, 1'b0, 7'd0},
        '{kst_pkg::RSHIFT_MAKE, 1'b0, 7'd0},
        '{kst_pkg::LSHIFT_BREAK, 1'b0, 7'd0}, // right shift still held
        '{BREAK_BIT | 8'd109, 1'b0, 7'd0},
        '{kst_pkg::RSHIFT_BREAK, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd109, 1'b0, 7'd0},
        '{kst_pkg::LSHIFT_MAKE, 1'b0, 7'd0},  // repeated press of one shift
        '{kst_pkg::LSHIFT_MAKE, 1'b0, 7'd0},
        '{BREAK_BIT | 8'd89, 1'b0, 7'd0}     // return key
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [kst_pkg::SCAN_W-1:0]   i_scan_code;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [kst_pkg::CHAR_W-1:0]   o_ascii_char;

    // hand-typed expectation travels with the word on the input side
    logic                         row_typed;
    logic [kst_pkg::CHAR_W-1:0]   row_ch;

    // predictor state and its own key tables
    kst_pkg::t_shift              held_shift = '0;
    logic [kst_pkg::CHAR_W-1:0]   lower_keys [128];
    logic [kst_pkg::CHAR_W-1:0]   upper_keys [128];
    logic [kst_pkg::CHAR_W-1:0]   pending_chars [$];
    int                           fail_count = 0;

    // receiver stall pattern state
    int                  stall_mode = 0;
    int                  stall_left = 0;
    int                  stall_tick = 0;

    keyboard_scancode_translator_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_scan_code  (i_scan_code),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ascii_char (o_ascii_char)
    );

    always #5ns i_clk = ~i_clk;

    // fill one run of consecutive keys in both tables
    task automatic fill_row(input int first, input string lower, input string upper);
        byte b;
        for (int i = 0; i < lower.len(); i++) begin
            b = lower[i];
            lower_keys[first + i] = b[kst_pkg::CHAR_W-1:0];
            b = upper[i];
            upper_keys[first + i] = b[kst_pkg::CHAR_W-1:0];
        end
    endtask

    // update the shift flags and return whether the byte makes a character
    function automatic bit translate_scan(input logic [kst_pkg::SCAN_W-1:0] code,
                                          output logic [kst_pkg::CHAR_W-1:0] ch);
        ch = '0;
        case (code)
            kst_pkg::LSHIFT_MAKE:  held_shift.left  = 1'b1;
            kst_pkg::RSHIFT_MAKE:  held_shift.right = 1'b1;
            kst_pkg::LSHIFT_BREAK: held_shift.left  = 1'b0;
            kst_pkg::RSHIFT_BREAK: held_shift.right = 1'b0;
            default: ;
        endcase
        if (!code[kst_pkg::SCAN_W-1] || code == kst_pkg::LSHIFT_BREAK
            || code == kst_pkg::RSHIFT_BREAK)
            return 1'b0;
        ch = (held_shift != '0) ? upper_keys[code[kst_pkg::KEY_W-1:0]]
                                : lower_keys[code[kst_pkg::KEY_W-1:0]];
        return 1'b1;
    endfunction

    // check output words, then predict for the accepted input word
    always @(posedge i_clk) begin
        logic [kst_pkg::CHAR_W-1:0] want;
        logic [kst_pkg::CHAR_W-1:0] ch;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_chars.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none got %0d",
                             $time, o_ascii_char);
                end else begin
                    want = pending_chars.pop_front();
                    if (want !== o_ascii_char) begin
                        fail_count++;
                        $display("%0t: ascii_char mismatch, expected %0d got %0d",
                                 $time, want, o_ascii_char);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (translate_scan(i_scan_code, ch))
                    pending_chars.push_back(row_typed ? row_ch : ch);
            end
        end
    end

    // receiver: phases of always ready, coin flips, sparse ready and long stalls
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 150);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= (stall_tick % 4 == 0);
            default: i_out_ready <= (stall_tick % 24 == 0);
        endcase
    end

    // present one word and hold it until it is taken
    task automatic send_scan(input logic [kst_pkg::SCAN_W-1:0] code, input logic typed,
                             input logic [kst_pkg::CHAR_W-1:0] ch);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_scan_code <= code;
        row_typed   <= typed;
        row_ch      <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // sender gap, with junk on the data lines
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_scan_code <= kst_pkg::SCAN_W'($urandom);
        end
    endtask

    // hold the sender off until every expected word has come out
    task automatic drain_results();
        idle_sender(1);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // random byte: shift traffic, releases of keys 30 to 121 and raw noise
    function automatic logic [kst_pkg::SCAN_W-1:0] pick_scan();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return $urandom_range(0, 1) ? kst_pkg::LSHIFT_MAKE : kst_pkg::RSHIFT_MAKE;
        if (r < 24)
            return $urandom_range(0, 1) ? kst_pkg::LSHIFT_BREAK : kst_pkg::RSHIFT_BREAK;
        if (r < 65)
            return BREAK_BIT | kst_pkg::SCAN_W'($urandom_range(30, 121));
        return kst_pkg::SCAN_W'($urandom_range(0, 255));
    endfunction

    // run limit
    initial begin
        #5ms;
        $display("keyboard_scancode_translator_top verification failed");
        $finish;
    end

    // stimulus
    initial begin
        logic [kst_pkg::SCAN_W-1:0] code;
        int                         counted;
        int                         burst_left;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_scan_code = '0;
        row_typed   = 1'b0;
        row_ch      = '0;

        for (int i = 0; i < 128; i++) begin
            lower_keys[i] = '0;
            upper_keys[i] = '0;
        end
        fill_row(30, "1234567890-=", "!@#$%^&*()_+");
        fill_row(54, "qwertyuiop[]", "QWERTYUIOP{}");
        fill_row(77, "asdfghjkl;'\\", "ASDFGHJKL:\"|");
        fill_row(100, "zxcvbnm,./", "ZXCVBNM<>?");
        lower_keys[43]  = 7'd8;
        upper_keys[43]  = 7'd8;
        lower_keys[53]  = 7'd9;
        upper_keys[53]  = 7'd9;
        lower_keys[89]  = 7'd13;
        upper_keys[89]  = 7'd13;
        lower_keys[121] = 7'd32;
        upper_keys[121] = 7'd32;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < NUM_ROWS; i++)
            send_scan(DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].ch);
        drain_results();

        // random bursts
        counted    = 0;
        burst_left = 0;
        while (counted < RANDOM_WORDS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 12));
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
            code = pick_scan();
            send_scan(code, 1'b0, '0);
            burst_left--;
            counted++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_chars.size() == 0) begin
            $display("keyboard_scancode_translator_top verification clean");
        end else begin
            $display("keyboard_scancode_translator_top verification failed");
        end
        $finish;
    end

endmodule
